/* rtl/pfla_pkg.sv */
// shared types and constants for the pool free list allocator
package pfla_pkg;

  // payload field widths
  localparam int REQ_W    = 2;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // default number of slots in the pool
  localparam int POOL_DEPTH_DEF = 1024;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC        = 2'd0,
    REQ_FREE         = 2'd1,
    REQ_COUNT_ACTIVE = 2'd2,
    REQ_COUNT_IDLE   = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE       = 2'd0,
    STAT_EMPTY      = 2'd1,
    STAT_NOT_ACTIVE = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_LINK,
    ST_ALLOC_FIX,
    ST_FREE_RD,
    ST_FREE_UNLINK,
    ST_FREE_PUSH,
    ST_FREE_FIX,
    ST_DONE
  } state_t;

endpackage

/* rtl/pfla_in_if.sv */
// request channel interface of the pool free list allocator
interface pfla_in_if;
  logic                          valid;
  logic                          ready;
  logic [pfla_pkg::REQ_W-1:0]    req_type;
  logic [pfla_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, output req_type, output slot, input ready);
  modport sink   (input valid, input req_type, input slot, output ready);
endinterface

/* rtl/pfla_out_if.sv */
// result channel interface of the pool free list allocator
interface pfla_out_if;
  logic                            valid;
  logic                            ready;
  logic [pfla_pkg::STATUS_W-1:0]   status;
  logic [pfla_pkg::SLOT_W-1:0]     granted_slot;
  logic [pfla_pkg::COUNT_W-1:0]    list_count;

  modport source (output valid, output status, output granted_slot, output list_count,
                  input ready);
  modport sink   (input valid, input status, input granted_slot, input list_count,
                  output ready);
endinterface

/* rtl/pfla_ram.sv */
// generic single write port ram with registered read
module pfla_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = pfla_pkg::POOL_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pool_free_list_allocator.sv */
// Pool slot allocator: POOL_DEPTH slots on an idle and an active doubly linked list.
// After reset the block runs a clearing pass that chains every slot in order on the
// idle list; no request is taken meanwhile. A request is accepted in the idle state,
// then a small sequencer drives the next-link, previous-link and active-mark RAMs (one
// write port and one registered read port each): an allocate steps through read, link
// and fix states, a free through read, unlink, push and fix (read and unlink only when
// the slot is not active), and a count, an out-of-range free or an allocate from an
// empty idle list goes straight to the done state, which loads the result register.
// The block is then idle again; the steps follow the up to three writes that an allocate
// or a free makes to the single write port of the previous-link RAM. The result register
// decouples the output: a new request is taken while the last result still waits.
module pool_free_list_allocator #(
  parameter int POOL_DEPTH = pfla_pkg::POOL_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pfla_in_if.sink    in_chan,
  pfla_out_if.source out_chan
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam logic [LW-1:0] NONE = LW'(POOL_DEPTH);
  localparam logic [16:0] DEPTH_EXT = 17'(POOL_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(POOL_DEPTH - 1);

  pfla_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [AW-1:0] s_r, s_nxt;
  logic [LW-1:0] after_r, after_nxt;
  logic [LW-1:0] active_head_r, active_head_nxt;
  logic [LW-1:0] idle_head_r, idle_head_nxt;
  logic [LW-1:0] active_total_r, active_total_nxt;
  logic [LW-1:0] idle_total_r, idle_total_nxt;

  logic [pfla_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [pfla_pkg::SLOT_W-1:0]   res_granted_r, res_granted_nxt;
  logic [pfla_pkg::COUNT_W-1:0]  res_count_r, res_count_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [pfla_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [pfla_pkg::SLOT_W-1:0]   out_granted_r, out_granted_nxt;
  logic [pfla_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  // link and mark ram ports
  logic          next_we, prev_we, mark_we;
  logic [AW-1:0] next_waddr, prev_waddr;
  logic [LW-1:0] next_wdata, prev_wdata, next_rdata, prev_rdata;
  logic [0:0]    mark_wdata, mark_rdata;

  logic          slot_in_range;
  logic [AW-1:0] slot_addr;
  logic          out_free;

  assign slot_in_range = 17'(in_chan.slot) < DEPTH_EXT;
  assign slot_addr     = AW'(in_chan.slot);
  assign out_free      = !out_valid_r || out_chan.ready;

  assign in_chan.ready         = (state_r == pfla_pkg::ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.granted_slot = out_granted_r;
  assign out_chan.list_count   = out_count_r;

  pfla_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (s_r),
    .rdata (next_rdata)
  );

  pfla_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (s_r),
    .rdata (prev_rdata)
  );

  pfla_ram #(.WIDTH(1), .DEPTH(POOL_DEPTH)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (s_r),
    .wdata (mark_wdata),
    .raddr (s_r),
    .rdata (mark_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfla_pkg::ST_CLEAR: begin
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = pfla_pkg::ST_IDLE;
        end
      end
      pfla_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          case (pfla_pkg::req_t'(in_chan.req_type))
            pfla_pkg::REQ_ALLOC: begin
              state_nxt = (idle_head_r < NONE) ? pfla_pkg::ST_ALLOC_RD : pfla_pkg::ST_DONE;
            end
            pfla_pkg::REQ_FREE: begin
              state_nxt = slot_in_range ? pfla_pkg::ST_FREE_RD : pfla_pkg::ST_DONE;
            end
            default: state_nxt = pfla_pkg::ST_DONE;
          endcase
        end
      end
      pfla_pkg::ST_ALLOC_RD:   state_nxt = pfla_pkg::ST_ALLOC_LINK;
      pfla_pkg::ST_ALLOC_LINK: state_nxt = pfla_pkg::ST_ALLOC_FIX;
      pfla_pkg::ST_ALLOC_FIX:  state_nxt = pfla_pkg::ST_DONE;
      pfla_pkg::ST_FREE_RD:    state_nxt = pfla_pkg::ST_FREE_UNLINK;
      pfla_pkg::ST_FREE_UNLINK: begin
        state_nxt = mark_rdata[0] ? pfla_pkg::ST_FREE_PUSH : pfla_pkg::ST_DONE;
      end
      pfla_pkg::ST_FREE_PUSH:  state_nxt = pfla_pkg::ST_FREE_FIX;
      pfla_pkg::ST_FREE_FIX:   state_nxt = pfla_pkg::ST_DONE;
      pfla_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = pfla_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pfla_pkg::ST_IDLE;
    endcase
  end

  // ram control, list heads, totals and result
  always_comb begin
    clr_idx_nxt      = clr_idx_r;
    s_nxt            = s_r;
    after_nxt        = after_r;
    active_head_nxt  = active_head_r;
    idle_head_nxt    = idle_head_r;
    active_total_nxt = active_total_r;
    idle_total_nxt   = idle_total_r;
    res_status_nxt   = res_status_r;
    res_granted_nxt  = res_granted_r;
    res_count_nxt    = res_count_r;
    out_valid_nxt    = out_valid_r && !out_chan.ready;
    out_status_nxt   = out_status_r;
    out_granted_nxt  = out_granted_r;
    out_count_nxt    = out_count_r;
    next_we          = 1'b0;
    next_waddr       = s_r;
    next_wdata       = NONE;
    prev_we          = 1'b0;
    prev_waddr       = s_r;
    prev_wdata       = NONE;
    mark_we          = 1'b0;
    mark_wdata       = 1'b0;

    case (state_r)
      // chain slot i to i+1 and i-1, clear its mark
      pfla_pkg::ST_CLEAR: begin
        next_we     = 1'b1;
        next_waddr  = clr_idx_r;
        next_wdata  = LW'(clr_idx_r) + LW'(1);
        prev_we     = 1'b1;
        prev_waddr  = clr_idx_r;
        prev_wdata  = (clr_idx_r == '0) ? NONE : LW'(clr_idx_r) - LW'(1);
        mark_we     = 1'b1;
        s_nxt       = clr_idx_r + AW'(1);
        clr_idx_nxt = clr_idx_r + AW'(1);
      end
      // decode a new transaction
      pfla_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          res_status_nxt  = pfla_pkg::STAT_DONE;
          res_granted_nxt = '0;
          res_count_nxt   = '0;
          case (pfla_pkg::req_t'(in_chan.req_type))
            pfla_pkg::REQ_ALLOC: begin
              s_nxt = idle_head_r[AW-1:0];
              if (idle_head_r >= NONE) begin
                res_status_nxt = pfla_pkg::STAT_EMPTY;
              end
            end
            pfla_pkg::REQ_FREE: begin
              s_nxt = slot_addr;
              if (!slot_in_range) begin
                res_status_nxt = pfla_pkg::STAT_NOT_ACTIVE;
              end
            end
            pfla_pkg::REQ_COUNT_ACTIVE: res_count_nxt = pfla_pkg::COUNT_W'(active_total_r);
            pfla_pkg::REQ_COUNT_IDLE:   res_count_nxt = pfla_pkg::COUNT_W'(idle_total_r);
            default: res_count_nxt = '0;
          endcase
        end
      end
      // read next link of the idle head, mark it active
      pfla_pkg::ST_ALLOC_RD: begin
        prev_we    = 1'b1;
        mark_we    = 1'b1;
        mark_wdata = 1'b1;
      end
      // link the slot in front of the active head
      pfla_pkg::ST_ALLOC_LINK: begin
        after_nxt  = next_rdata;
        next_we    = 1'b1;
        next_wdata = active_head_r;
        if (active_head_r < NONE) begin
          prev_we    = 1'b1;
          prev_waddr = active_head_r[AW-1:0];
          prev_wdata = LW'(s_r);
        end
      end
      // detach the new idle head, move both heads
      pfla_pkg::ST_ALLOC_FIX: begin
        if (after_r < NONE) begin
          prev_we    = 1'b1;
          prev_waddr = after_r[AW-1:0];
          prev_wdata = NONE;
        end
        idle_head_nxt    = after_r;
        active_head_nxt  = LW'(s_r);
        idle_total_nxt   = idle_total_r - LW'(1);
        active_total_nxt = active_total_r + LW'(1);
        res_granted_nxt  = pfla_pkg::SLOT_W'(s_r);
      end
      // bridge the neighbors of the freed slot
      pfla_pkg::ST_FREE_UNLINK: begin
        if (mark_rdata[0]) begin
          after_nxt = next_rdata;
          if (prev_rdata < NONE) begin
            next_we    = 1'b1;
            next_waddr = prev_rdata[AW-1:0];
            next_wdata = next_rdata;
          end
          if (next_rdata < NONE) begin
            prev_we    = 1'b1;
            prev_waddr = next_rdata[AW-1:0];
            prev_wdata = prev_rdata;
          end
          mark_we = 1'b1;
          if (active_head_r == LW'(s_r)) begin
            active_head_nxt = next_rdata;
          end
          active_total_nxt = active_total_r - LW'(1);
        end else begin
          res_status_nxt = pfla_pkg::STAT_NOT_ACTIVE;
        end
      end
      // point the freed slot at the idle head
      pfla_pkg::ST_FREE_PUSH: begin
        next_we    = 1'b1;
        next_wdata = idle_head_r;
        prev_we    = 1'b1;
      end
      // back link from the old idle head, move the idle head
      pfla_pkg::ST_FREE_FIX: begin
        if (idle_head_r < NONE) begin
          prev_we    = 1'b1;
          prev_waddr = idle_head_r[AW-1:0];
          prev_wdata = LW'(s_r);
        end
        idle_head_nxt  = LW'(s_r);
        idle_total_nxt = idle_total_r + LW'(1);
      end
      // load the result register
      pfla_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_granted_nxt = res_granted_r;
          out_count_nxt   = res_count_r;
        end
      end
      default: begin
        after_nxt = after_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= pfla_pkg::ST_CLEAR;
      clr_idx_r      <= '0;
      s_r            <= '0;
      active_head_r  <= NONE;
      idle_head_r    <= '0;
      active_total_r <= '0;
      idle_total_r   <= NONE;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_idx_r      <= clr_idx_nxt;
      s_r            <= s_nxt;
      active_head_r  <= active_head_nxt;
      idle_head_r    <= idle_head_nxt;
      active_total_r <= active_total_nxt;
      idle_total_r   <= idle_total_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    after_r       <= after_nxt;
    res_status_r  <= res_status_nxt;
    res_granted_r <= res_granted_nxt;
    res_count_r   <= res_count_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_count_r   <= out_count_nxt;
  end

`ifndef SYNTHESIS
  // between transactions the two list totals add up to the pool depth
  a_totals_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfla_pkg::ST_IDLE) |->
      (({1'b0, active_total_r} + {1'b0, idle_total_r}) == (LW + 1)'(POOL_DEPTH)))
    else $error("list totals do not add up to the pool depth");

  // an empty active list has no head
  a_active_head: assert property (@(posedge clk) disable iff (!rst_n)
    (active_head_r == NONE) == (active_total_r == '0))
    else $error("active head and active total disagree");

  // an empty idle list has no head
  a_idle_head: assert property (@(posedge clk) disable iff (!rst_n)
    (idle_head_r == NONE) == (idle_total_r == '0))
    else $error("idle head and idle total disagree");

  // an accepted transaction keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request accepted on back to back cycles");
`endif

endmodule
